[rtl/wrm_pkg.sv]
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared widths and the operation codes of the arithmetic unit.
// ----------------------------------------------------------------------------
package wrm_pkg;

    localparam int OPERAND_BITS_DEFAULT = 62;
    localparam int NUM_IN_BITS          = 63;
    localparam int DEN_IN_BITS          = 62;
    localparam int HIGH_BITS            = 60;
    localparam int LOW_BITS             = 64;

    typedef enum logic [1:0] {
        OP_DIV = 2'd0,
        OP_MUL = 2'd1
    } wrm_op_t;

    typedef struct packed {
        logic    start;
        wrm_op_t op;
    } wrm_cmd_t;

endpackage

[rtl/word_rational_multiply.sv]
// ----------------------------------------------------------------------------
// word_rational_multiply
// Product of two word rationals with gcd cross-cancellation.
// ----------------------------------------------------------------------------
// One item at a time. After a transfer the sequencer runs every step through
// one shared divide/multiply unit (start, one bit a cycle, then the done
// handshake): each gcd that runs takes one pass per Euclid step (at most
// about 1.44*OPERAND_BITS steps), then four exact divisions and two
// multiplications. A zero numerator goes straight to the output state;
// equal denominators take two passes, the two multiplications. The result
// sits in an output register; in_stall is high while an item is in progress
// or a result waits.
module word_rational_multiply
    import wrm_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [NUM_IN_BITS-1:0] first_numerator,
    input  logic [DEN_IN_BITS-1:0] first_denominator,
    input  logic [NUM_IN_BITS-1:0] second_numerator,
    input  logic [DEN_IN_BITS-1:0] second_denominator,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   product_negative,
    output logic [HIGH_BITS-1:0]   numerator_high,
    output logic [LOW_BITS-1:0]    numerator_low,
    output logic [HIGH_BITS-1:0]   denominator_high,
    output logic [LOW_BITS-1:0]    denominator_low
);

    localparam int W = OPERAND_BITS;
    localparam logic [W-1:0] OMAX = {W{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_G_DIV, S_G_WAIT, S_H_DIV, S_H_WAIT,
        S_CAN, S_CAN_WAIT, S_MUL, S_MUL_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [W-1:0] n1_reg, n2_reg, d1_reg, d2_reg, g_reg, h_reg;
    logic [W-1:0] ga_reg, gb_reg;
    logic [1:0]   step_reg;
    logic         neg_reg, zero_reg;
    logic [2*W-1:0] pn_reg;

    wrm_cmd_t       cmd;
    logic [W-1:0]   alu_a, alu_b, quo, rem;
    logic [2*W-1:0] prod;
    logic           done;

    wrm_alu #(.W(W)) u_alu (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .a(alu_a), .b(alu_b),
        .done(done), .quo(quo), .rem(rem), .prod(prod)
    );

    // Saturating magnitude of a 63-bit numerator.
    function automatic logic [W-1:0] mag(input logic [NUM_IN_BITS-1:0] v);
        logic [NUM_IN_BITS:0] m;
        m = v[NUM_IN_BITS-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
        if (m > {{(NUM_IN_BITS+1-W){1'b0}}, OMAX})
        begin
            mag = OMAX;
        end
        else
        begin
            mag = m[W-1:0];
        end
    endfunction

    logic [2*W-1:0] pn_w, pd_w;
    assign pn_w = pn_reg;
    assign pd_w = prod;

    always_comb
    begin
        cmd.start = 1'b0;
        cmd.op    = OP_DIV;
        alu_a     = ga_reg;
        alu_b     = gb_reg;
        case (state_reg)
            S_G_DIV, S_H_DIV:
            begin
                // a zero divisor ends Euclid here, so leave the unit idle
                cmd.start = (gb_reg != '0);
            end
            S_CAN:
            begin
                cmd.start = 1'b1;
                case (step_reg)
                    2'd0:    begin alu_a = n1_reg; alu_b = g_reg; end
                    2'd1:    begin alu_a = d2_reg; alu_b = g_reg; end
                    2'd2:    begin alu_a = n2_reg; alu_b = h_reg; end
                    default: begin alu_a = d1_reg; alu_b = h_reg; end
                endcase
            end
            S_MUL:
            begin
                cmd.start = 1'b1;
                cmd.op    = OP_MUL;
                if (step_reg == 2'd0)
                begin
                    alu_a = n1_reg; alu_b = n2_reg;
                end
                else
                begin
                    alu_a = d1_reg; alu_b = d2_reg;
                end
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        n1_reg    <= mag(first_numerator);
                        n2_reg    <= mag(second_numerator);
                        d1_reg    <= W'({1'b0, first_denominator});
                        d2_reg    <= W'({1'b0, second_denominator});
                        neg_reg   <= first_numerator[NUM_IN_BITS-1]
                                     ^ second_numerator[NUM_IN_BITS-1];
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    zero_reg <= (n1_reg == '0 || n2_reg == '0);
                    step_reg <= 2'd0;
                    if (n1_reg == '0 || n2_reg == '0)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (d1_reg == d2_reg)
                    begin
                        state_reg <= S_MUL;
                    end
                    else if (d2_reg == W'(1) && d1_reg != W'(1))
                    begin
                        g_reg     <= W'(1);
                        ga_reg    <= n2_reg;
                        gb_reg    <= d1_reg;
                        state_reg <= S_H_DIV;
                    end
                    else
                    begin
                        ga_reg    <= n1_reg;
                        gb_reg    <= d2_reg;
                        state_reg <= S_G_DIV;
                    end
                end
                S_G_DIV, S_H_DIV:
                begin
                    if (gb_reg == '0)
                    begin
                        if (state_reg == S_G_DIV)
                        begin
                            g_reg <= ga_reg;
                            if (d1_reg == W'(1) && d2_reg != W'(1))
                            begin
                                h_reg     <= W'(1);
                                state_reg <= S_CAN;
                            end
                            else
                            begin
                                ga_reg    <= n2_reg;
                                gb_reg    <= d1_reg;
                                state_reg <= S_H_DIV;
                            end
                        end
                        else
                        begin
                            h_reg     <= ga_reg;
                            state_reg <= S_CAN;
                        end
                    end
                    else
                    begin
                        state_reg <= (state_reg == S_G_DIV) ? S_G_WAIT : S_H_WAIT;
                    end
                end
                S_G_WAIT, S_H_WAIT:
                begin
                    if (done)
                    begin
                        ga_reg    <= gb_reg;
                        gb_reg    <= rem;
                        state_reg <= (state_reg == S_G_WAIT) ? S_G_DIV : S_H_DIV;
                    end
                end
                S_CAN:
                begin
                    state_reg <= S_CAN_WAIT;
                end
                S_CAN_WAIT:
                begin
                    if (done)
                    begin
                        case (step_reg)
                            2'd0:    n1_reg <= quo;
                            2'd1:    d2_reg <= quo;
                            2'd2:    n2_reg <= quo;
                            default: d1_reg <= quo;
                        endcase
                        step_reg  <= step_reg + 2'd1;
                        state_reg <= (step_reg == 2'd3) ? S_MUL : S_CAN;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_MUL_WAIT;
                end
                S_MUL_WAIT:
                begin
                    if (done)
                    begin
                        if (step_reg == 2'd0)
                        begin
                            pn_reg    <= prod;
                            step_reg  <= 2'd1;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid)
                    begin
                        out_valid        <= 1'b1;
                        product_negative <= zero_reg ? 1'b0 : neg_reg;
                        numerator_high   <= zero_reg ? '0
                                            : HIGH_BITS'(pn_w >> LOW_BITS);
                        numerator_low    <= zero_reg ? '0 : LOW_BITS'(pn_w);
                        denominator_high <= zero_reg ? '0
                                            : HIGH_BITS'(pd_w >> LOW_BITS);
                        denominator_low  <= zero_reg ? LOW_BITS'(1) : LOW_BITS'(pd_w);
                    end
                    else if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Accept only when idle; never offer a result outside the output state.
    property p_accept_idle;
        @(posedge clk) disable iff (!rst_n)
            (in_valid && !in_stall) |=> (state_reg == S_PREP);
    endproperty
    a_accept_idle: assert property (p_accept_idle) else $error("bad accept");

    property p_out_state;
        @(posedge clk) disable iff (!rst_n) out_valid |-> (state_reg == S_OUT);
    endproperty
    a_out_state: assert property (p_out_state) else $error("result outside output state");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            (out_valid && out_stall) |=> (out_valid && $stable(numerator_low));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

endmodule

[rtl/wrm_alu.sv]
// ----------------------------------------------------------------------------
// wrm_alu
// Shared unit: restoring division (quotient and remainder, one bit a cycle)
// or shift-add multiplication (one multiplier bit a cycle).
// ----------------------------------------------------------------------------
module wrm_alu
    import wrm_pkg::*;
#(
    parameter int W = OPERAND_BITS_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  wrm_cmd_t       cmd,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [W-1:0]   quo,
    output logic [W-1:0]   rem,
    output logic [2*W-1:0] prod
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    wrm_op_t        op_reg;
    logic [W-1:0]   b_reg;
    logic [W-1:0]   q_reg;
    logic [W:0]     r_reg;
    logic [2*W-1:0] acc_reg;
    logic [2*W-1:0] mc_reg;

    logic [W:0] r_sh;
    logic [W:0] r_sub;

    assign r_sh  = {r_reg[W-1:0], q_reg[W-1]};
    assign r_sub = r_sh - {1'b0, b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                done     <= 1'b0;
                cnt_reg  <= CW'(W);
                op_reg   <= cmd.op;
                b_reg    <= b;
                q_reg    <= a;
                r_reg    <= '0;
                acc_reg  <= '0;
                mc_reg   <= {{W{1'b0}}, a};
            end
            else if (busy_reg)
            begin
                case (op_reg)
                    OP_DIV:
                    begin
                        if (!r_sub[W])
                        begin
                            r_reg <= r_sub;
                            q_reg <= {q_reg[W-2:0], 1'b1};
                        end
                        else
                        begin
                            r_reg <= r_sh;
                            q_reg <= {q_reg[W-2:0], 1'b0};
                        end
                    end
                    OP_MUL:
                    begin
                        if (b_reg[0])
                        begin
                            acc_reg <= acc_reg + mc_reg;
                        end
                        mc_reg <= {mc_reg[2*W-2:0], 1'b0};
                        b_reg  <= {1'b0, b_reg[W-1:1]};
                    end
                    default:
                    begin
                        r_reg <= r_reg;
                    end
                endcase
                cnt_reg  <= cnt_reg - 1'b1;
                busy_reg <= (cnt_reg != CW'(1));
                done     <= (cnt_reg == CW'(1));
            end
            else
            begin
                done <= 1'b0;
            end
        end
    end

    assign quo  = q_reg;
    assign rem  = r_reg[W-1:0];
    assign prod = acc_reg;

    property p_done_pulse;
        @(posedge clk) disable iff (!rst_n) done |=> !done;
    endproperty
    a_done_pulse: assert property (p_done_pulse) else $error("done held");

    property p_done_end;
        @(posedge clk) disable iff (!rst_n) done |-> !busy_reg;
    endproperty
    a_done_end: assert property (p_done_end) else $error("done while busy");

    property p_no_restart;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> !cmd.start;
    endproperty
    a_no_restart: assert property (p_no_restart) else $error("start while busy");

endmodule
